// ===== rtl/core/lbtv_pkg.sv =====
// ----------------------------------------------------------------------------
// lbtv_pkg
// Types and constants shared by the three-vector boost pipeline.
// ----------------------------------------------------------------------------
package lbtv_pkg;

  localparam int unsigned THR_W       = 61;
  localparam int unsigned ROOT_W      = 31;
  localparam int unsigned RAD_W       = 2 * ROOT_W;
  localparam int unsigned REM_W       = ROOT_W + 2;
  localparam int unsigned DEN_W       = 62;
  localparam int unsigned AVM_W       = 62;
  localparam int unsigned QUO_W       = 79;
  localparam int unsigned DIV_INIT_W  = AVM_W + 46 - QUO_W;
  localparam int unsigned PROD_W      = 112;
  localparam int unsigned CORR_W      = 35;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_PASS    = 2'd1;
  localparam logic [1:0] ST_INVALID = 2'd2;
  localparam logic [1:0] ST_SAT     = 2'd3;

  typedef struct packed {
    logic              opcode;
    logic signed [31:0] a_x;
    logic signed [31:0] a_y;
    logic signed [31:0] a_z;
    logic signed [31:0] v_x;
    logic signed [31:0] v_y;
    logic signed [31:0] v_z;
  } lbtv_in_t;

  typedef struct packed {
    logic signed [31:0] g_x;
    logic signed [31:0] g_y;
    logic signed [31:0] g_z;
    logic [1:0]         status;
  } lbtv_out_t;

  typedef struct packed {
    logic [1:0]       status;
    logic             inv;
    logic             mneg;
    logic [AVM_W-1:0] avm;
    logic [2:0][31:0] a;
    logic [2:0][31:0] v;
  } lbtv_side_t;

endpackage

// ===== rtl/core/lorentz_boost_three_vector.sv =====
// ----------------------------------------------------------------------------
// lorentz_boost_three_vector
// Fixed-point Lorentz boost of a spatial vector, fully pipelined.
// The 31-stage square root and 79-stage divider are the longest sections.
// Throughput: one item per cycle, busy stays low. Synchronous active-low
// reset clears all valid bits and sets the threshold to 256; results
// cannot be stalled by the receiver.
// ----------------------------------------------------------------------------
module lorentz_boost_three_vector (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  output logic                        busy,
  input  lbtv_pkg::lbtv_in_t          in_item,
  output logic                        out_strobe,
  output lbtv_pkg::lbtv_out_t         out_item,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [lbtv_pkg::THR_W-1:0]  cfg_data
);
  import lbtv_pkg::*;

  logic [THR_W-1:0] thr_r;

  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r <= THR_W'(256);
    end else if (cfg_valid && cfg_ready) begin
      thr_r <= cfg_data;
    end
  end

  // products
  logic [2:0][31:0]         in_a;
  logic [2:0][31:0]         in_v;
  logic                     s1_valid_r;
  logic                     s1_inv_r;
  logic [2:0][31:0]         s1_a_r;
  logic [2:0][31:0]         s1_v_r;
  logic [2:0][63:0]         s1_sq_r;
  logic [2:0][63:0]         s1_av_r;

  assign in_a = {in_item.a_z, in_item.a_y, in_item.a_x};
  assign in_v = {in_item.v_z, in_item.v_y, in_item.v_x};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= start && !busy;
    end
  end

  always_ff @(posedge clk) begin
    s1_inv_r <= in_item.opcode;
    s1_a_r   <= in_a;
    s1_v_r   <= in_v;
    for (int i = 0; i < 3; i++) begin
      s1_sq_r[i] <= 64'($signed(in_v[i]) * $signed(in_v[i]));
      s1_av_r[i] <= 64'($signed(in_a[i]) * $signed(in_v[i]));
    end
  end

  // sums and classification
  logic [63:0]        vv;
  logic signed [63:0] av;
  logic [AVM_W-1:0]   avm;
  logic               s2_valid_r;
  lbtv_side_t         s2_side_r;
  logic [RAD_W-1:0]   s2_rad_r;

  always_comb begin
    vv = s1_sq_r[0] + s1_sq_r[1] + s1_sq_r[2];
    av = '0;
    for (int i = 0; i < 3; i++) begin
      av = av + ($signed(s1_av_r[i] + (s1_av_r[i][63] ? 64'd3 : 64'd0)) >>> 2);
    end
    avm = av[63] ? AVM_W'(-av) : AVM_W'(av);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r <= 1'b0;
    end else begin
      s2_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    priority if (vv <= {3'd0, thr_r}) begin
      s2_side_r.status <= ST_PASS;
    end else if (vv >= (64'd1 << 60)) begin
      s2_side_r.status <= ST_INVALID;
    end else begin
      s2_side_r.status <= ST_OK;
    end
    s2_side_r.inv  <= s1_inv_r;
    s2_side_r.mneg <= av[63] != s1_inv_r;
    s2_side_r.avm  <= avm;
    s2_side_r.a    <= s1_a_r;
    s2_side_r.v    <= s1_v_r;
    s2_rad_r       <= RAD_W'((64'd1 << 60) - vv);
  end

  // square root
  logic              sq_valid;
  lbtv_side_t        sq_side;
  logic [ROOT_W-1:0] sq_root;

  lbtv_isqrt u_isqrt (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (s2_valid_r),
    .in_side   (s2_side_r),
    .in_rad    (s2_rad_r),
    .out_valid (sq_valid),
    .out_side  (sq_side),
    .out_root  (sq_root)
  );

  // denominator
  logic [ROOT_W:0]  root_sum;
  logic             dn_valid_r;
  lbtv_side_t       dn_side_r;
  logic [DEN_W-1:0] dn_den_r;

  assign root_sum = (ROOT_W+1)'(1 << 30) + (ROOT_W+1)'(sq_root);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dn_valid_r <= 1'b0;
    end else begin
      dn_valid_r <= sq_valid;
    end
  end

  always_ff @(posedge clk) begin
    dn_side_r <= sq_side;
    dn_den_r  <= sq_side.inv ? DEN_W'({root_sum, 30'd0})
                             : DEN_W'(sq_root * root_sum);
  end

  // divide
  logic             dv_valid;
  lbtv_side_t       dv_side;
  logic [QUO_W-1:0] dv_quo;

  lbtv_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (dn_valid_r),
    .in_side   (dn_side_r),
    .in_den    (dn_den_r),
    .out_valid (dv_valid),
    .out_side  (dv_side),
    .out_quo   (dv_quo)
  );

  // partial products
  logic [QUO_W-1:0]      mc;
  logic [2:0][31:0]      vm;
  logic                  pp_valid_r;
  lbtv_side_t            pp_side_r;
  logic [2:0][2:0][58:0] pp_r;

  assign mc = dv_quo[QUO_W-1] ? {1'b1, (QUO_W-1)'(0)} : dv_quo;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      vm[i] = dv_side.v[i][31] ? 32'(-dv_side.v[i]) : dv_side.v[i];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pp_valid_r <= 1'b0;
    end else begin
      pp_valid_r <= dv_valid;
    end
  end

  always_ff @(posedge clk) begin
    pp_side_r <= dv_side;
    for (int i = 0; i < 3; i++) begin
      pp_r[i][0] <= 59'(mc[26:0] * vm[i]);
      pp_r[i][1] <= 59'(mc[53:27] * vm[i]);
      pp_r[i][2] <= 59'(mc[78:54] * vm[i]);
    end
  end

  // full products with rounding
  logic                    pr_valid_r;
  lbtv_side_t              pr_side_r;
  logic [2:0][PROD_W-1:0]  pr_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pr_valid_r <= 1'b0;
    end else begin
      pr_valid_r <= pp_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    pr_side_r <= pp_side_r;
    for (int i = 0; i < 3; i++) begin
      pr_r[i] <= PROD_W'(pp_r[i][0]) + (PROD_W'(pp_r[i][1]) << 27)
               + (PROD_W'(pp_r[i][2]) << 54) + (PROD_W'(1) << 43);
    end
  end

  // correction, saturation, output
  logic [2:0][31:0]   g;
  logic [2:0]         sat;
  logic [1:0]         status;
  logic               out_strobe_r;
  lbtv_out_t          out_item_r;

  always_comb begin
    logic [CORR_W-1:0]  corr;
    logic signed [36:0] ga;
    logic signed [36:0] gs;
    logic               neg;
    for (int i = 0; i < 3; i++) begin
      if ((|pr_r[i][PROD_W-1:79]) || (pr_r[i][78:44] > (CORR_W'(1) << 34))) begin
        corr = CORR_W'(1) << 34;
      end else begin
        corr = pr_r[i][78:44];
      end
      ga  = 37'($signed(pr_side_r.a[i]));
      neg = pr_side_r.v[i][31] != pr_side_r.mneg;
      gs  = neg ? ga - $signed({2'b00, corr}) : ga + $signed({2'b00, corr});
      sat[i] = 1'b0;
      if (pr_side_r.status != ST_OK) begin
        g[i] = pr_side_r.a[i];
      end else if (gs > 37'sh0_7FFF_FFFF) begin
        g[i]   = 32'h7FFF_FFFF;
        sat[i] = 1'b1;
      end else if (gs < -37'sh0_8000_0000) begin
        g[i]   = 32'h8000_0000;
        sat[i] = 1'b1;
      end else begin
        g[i] = gs[31:0];
      end
    end
    status = (pr_side_r.status == ST_OK && (|sat)) ? ST_SAT : pr_side_r.status;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_strobe_r <= 1'b0;
    end else begin
      out_strobe_r <= pr_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    out_item_r.g_x    <= g[0];
    out_item_r.g_y    <= g[1];
    out_item_r.g_z    <= g[2];
    out_item_r.status <= status;
  end

  assign out_strobe = out_strobe_r;
  assign out_item   = out_item_r;

endmodule

// ===== rtl/core/lbtv_isqrt.sv =====
// ----------------------------------------------------------------------------
// lbtv_isqrt
// Pipelined integer square root, one root bit per register stage.
// ----------------------------------------------------------------------------
module lbtv_isqrt (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  input  lbtv_pkg::lbtv_side_t      in_side,
  input  logic [lbtv_pkg::RAD_W-1:0] in_rad,
  output logic                      out_valid,
  output lbtv_pkg::lbtv_side_t      out_side,
  output logic [lbtv_pkg::ROOT_W-1:0] out_root
);
  import lbtv_pkg::*;

  logic                    valid_r [0:ROOT_W-1];
  lbtv_side_t              side_r  [0:ROOT_W-1];
  logic [RAD_W-1:0]        rad_r   [0:ROOT_W-1];
  logic [REM_W-1:0]        rem_r   [0:ROOT_W-1];
  logic [ROOT_W-1:0]       root_r  [0:ROOT_W-1];

  for (genvar k = 0; k < ROOT_W; k++) begin : g_stage
    logic              valid_in;
    lbtv_side_t        side_in;
    logic [RAD_W-1:0]  rad_in;
    logic [REM_W-1:0]  rem_in;
    logic [ROOT_W-1:0] root_in;
    logic [REM_W+1:0]  rem_sh;
    logic [REM_W+1:0]  trial;
    logic              take;

    if (k == 0) begin : g_first
      assign valid_in = in_valid;
      assign side_in  = in_side;
      assign rad_in   = in_rad;
      assign rem_in   = '0;
      assign root_in  = '0;
    end else begin : g_next
      assign valid_in = valid_r[k-1];
      assign side_in  = side_r[k-1];
      assign rad_in   = rad_r[k-1];
      assign rem_in   = rem_r[k-1];
      assign root_in  = root_r[k-1];
    end

    assign rem_sh = {rem_in, rad_in[RAD_W-1 -: 2]};
    assign trial  = {1'b0, root_in, 2'b01};
    assign take   = rem_sh >= trial;

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        valid_r[k] <= 1'b0;
      end else begin
        valid_r[k] <= valid_in;
      end
    end

    always_ff @(posedge clk) begin
      side_r[k] <= side_in;
      rad_r[k]  <= {rad_in[RAD_W-3:0], 2'b00};
      rem_r[k]  <= take ? REM_W'(rem_sh - trial) : REM_W'(rem_sh);
      root_r[k] <= {root_in[ROOT_W-2:0], take};
    end
  end

  assign out_valid = valid_r[ROOT_W-1];
  assign out_side  = side_r[ROOT_W-1];
  assign out_root  = root_r[ROOT_W-1];

endmodule

// ===== rtl/core/lbtv_div.sv =====
// ----------------------------------------------------------------------------
// lbtv_div
// Pipelined restoring divider, one quotient bit per register stage.
// ----------------------------------------------------------------------------
module lbtv_div (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  input  lbtv_pkg::lbtv_side_t       in_side,
  input  logic [lbtv_pkg::DEN_W-1:0] in_den,
  output logic                       out_valid,
  output lbtv_pkg::lbtv_side_t       out_side,
  output logic [lbtv_pkg::QUO_W-1:0] out_quo
);
  import lbtv_pkg::*;

  logic              valid_r [0:QUO_W-1];
  lbtv_side_t        side_r  [0:QUO_W-1];
  logic [DEN_W-1:0]  den_r   [0:QUO_W-1];
  logic [DEN_W-1:0]  rem_r   [0:QUO_W-1];
  logic [QUO_W-1:0]  num_r   [0:QUO_W-1];
  logic [QUO_W-1:0]  quo_r   [0:QUO_W-1];

  for (genvar k = 0; k < QUO_W; k++) begin : g_stage
    logic             valid_in;
    lbtv_side_t       side_in;
    logic [DEN_W-1:0] den_in;
    logic [DEN_W-1:0] rem_in;
    logic [QUO_W-1:0] num_in;
    logic [QUO_W-1:0] quo_in;
    logic [DEN_W:0]   rem_sh;
    logic             take;

    if (k == 0) begin : g_first
      assign valid_in = in_valid;
      assign side_in  = in_side;
      assign den_in   = in_den;
      assign rem_in   = DEN_W'(in_side.avm[AVM_W-1 -: DIV_INIT_W]);
      assign num_in   = {in_side.avm[AVM_W-DIV_INIT_W-1:0], 46'd0};
      assign quo_in   = '0;
    end else begin : g_next
      assign valid_in = valid_r[k-1];
      assign side_in  = side_r[k-1];
      assign den_in   = den_r[k-1];
      assign rem_in   = rem_r[k-1];
      assign num_in   = num_r[k-1];
      assign quo_in   = quo_r[k-1];
    end

    assign rem_sh = {rem_in, num_in[QUO_W-1]};
    assign take   = rem_sh >= {1'b0, den_in};

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        valid_r[k] <= 1'b0;
      end else begin
        valid_r[k] <= valid_in;
      end
    end

    always_ff @(posedge clk) begin
      side_r[k] <= side_in;
      den_r[k]  <= den_in;
      rem_r[k]  <= take ? DEN_W'(rem_sh - {1'b0, den_in}) : DEN_W'(rem_sh);
      num_r[k]  <= {num_in[QUO_W-2:0], 1'b0};
      quo_r[k]  <= {quo_in[QUO_W-2:0], take};
    end
  end

  assign out_valid = valid_r[QUO_W-1];
  assign out_side  = side_r[QUO_W-1];
  assign out_quo   = quo_r[QUO_W-1];

endmodule

// ===== sim/lorentz_boost_three_vector_tb.sv =====
// ----------------------------------------------------------------------------
// lorentz_boost_three_vector_tb
// Drives vectors and velocities into the boost pipeline, predicts each
// boosted vector and its status in bit-exact fixed point, and compares
// every strobed result in order. Covers several threshold settings, the
// passthrough, invalid and saturating cases, and random idle gaps.
// ----------------------------------------------------------------------------
module lorentz_boost_three_vector_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import lbtv_pkg::*;

  localparam int unsigned LATENCY   = 116;
  localparam longint      CYCLE_CAP = 400000;
  localparam logic [63:0] ONE_Q60   = 64'd1 << 60;
  localparam logic [63:0] ONE_Q30   = 64'd1 << 30;
  localparam logic [63:0] CORR_CAP  = 64'd1 << 34;
  localparam logic        OP_GAMMA  = 1'b0;
  localparam logic        OP_INV    = 1'b1;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  lbtv_in_t in_item = '0;
  logic out_strobe;
  lbtv_out_t out_item;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [THR_W-1:0] cfg_data = '0;

  lbtv_in_t  pending_items[$];
  lbtv_out_t boosted_due[$];
  logic [THR_W-1:0] thr_model;
  logic idle_on = 1'b1;
  logic hold_sender = 1'b0;
  int  mismatches = 0;
  int  results_seen = 0;
  int  status_seen[4] = '{0, 0, 0, 0};
  longint cycles = 0;

  lorentz_boost_three_vector u_top (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_item(in_item),
    .out_strobe(out_strobe), .out_item(out_item), .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic logic [63:0] int_sqrt(input logic [63:0] w);
    logic [63:0] res, bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > w) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (w >= res + bitv) begin
        w = w - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    return res;
  endfunction

  function automatic lbtv_out_t boost_vector(input lbtv_in_t it, input logic [THR_W-1:0] thr);
    lbtv_out_t r;
    logic signed [63:0] a[3], v[3], av, g;
    logic [63:0] vv, s, d, avm, vm, corr;
    logic [127:0] num, m, p;
    logic inv, mneg;
    a[0] = it.a_x; a[1] = it.a_y; a[2] = it.a_z;
    v[0] = it.v_x; v[1] = it.v_y; v[2] = it.v_z;
    inv = it.opcode;
    vv = 0;
    for (int i = 0; i < 3; i++) vv = vv + 64'(v[i] * v[i]);
    r.g_x = it.a_x; r.g_y = it.a_y; r.g_z = it.a_z;
    if (vv <= {3'b0, thr}) begin
      r.status = ST_PASS;
      return r;
    end
    if (vv >= ONE_Q60) begin
      r.status = ST_INVALID;
      return r;
    end
    r.status = ST_OK;
    av = 0;
    for (int i = 0; i < 3; i++) av = av + (a[i] * v[i]) / 4;
    s = int_sqrt(ONE_Q60 - vv);
    d = inv ? ONE_Q30 * (ONE_Q30 + s) : s * (ONE_Q30 + s);
    avm = av < 0 ? -av : av;
    mneg = (av < 0) != inv;
    num = {64'd0, avm} << 46;
    m = num / {64'd0, d};
    for (int i = 0; i < 3; i++) begin
      vm = v[i] < 0 ? -v[i] : v[i];
      p = m * {64'd0, vm} + (128'd1 << 43);
      corr = (p >> 44) > {64'd0, CORR_CAP} ? CORR_CAP : 64'(p >> 44);
      g = ((v[i] < 0) != mneg) ? a[i] - $signed(corr) : a[i] + $signed(corr);
      if (g > 64'sh7FFFFFFF) begin
        g = 64'sh7FFFFFFF;
        r.status = ST_SAT;
      end else if (g < -64'sh80000000) begin
        g = -64'sh80000000;
        r.status = ST_SAT;
      end
      if (i == 0) r.g_x = g[31:0];
      else if (i == 1) r.g_y = g[31:0];
      else r.g_z = g[31:0];
    end
    return r;
  endfunction

  function automatic logic signed [31:0] rand_speed();
    case ($urandom_range(0, 5))
      0: return $signed($urandom_range(0, 32'h7FFF_FFFF)) - 32'sh4000_0000;
      1: return $signed($urandom_range(0, 2000)) - 1000;
      2: return $urandom();
      default: return $signed($urandom_range(0, 32'h4000_0000)) - 32'sh2000_0000;
    endcase
  endfunction

  function automatic logic signed [31:0] rand_comp();
    case ($urandom_range(0, 3))
      0: return $urandom();
      1: return $signed($urandom_range(0, 32'h00FF_FFFF)) - 32'sh0080_0000;
      default: return $signed($urandom_range(0, 32'h1FFF_FFFF)) - 32'sh1000_0000;
    endcase
  endfunction

  function automatic lbtv_in_t make_item(input logic op, input logic signed [31:0] ax,
      input logic signed [31:0] ay, input logic signed [31:0] az,
      input logic signed [31:0] vx, input logic signed [31:0] vy,
      input logic signed [31:0] vz);
    lbtv_in_t it;
    it.opcode = op;
    it.a_x = ax; it.a_y = ay; it.a_z = az;
    it.v_x = vx; it.v_y = vy; it.v_z = vz;
    return it;
  endfunction

  always @(negedge clk) begin
    if (rst_n && start && !busy) begin
      boosted_due.push_back(boost_vector(in_item, thr_model));
      void'(pending_items.pop_front());
    end
    if (!rst_n || hold_sender || pending_items.size() == 0 ||
        (idle_on && $urandom_range(0, 99) < 33)) begin
      start <= 1'b0;
    end else begin
      start <= 1'b1;
      in_item <= pending_items[0];
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (rst_n && out_strobe) begin
      results_seen <= results_seen + 1;
      if (boosted_due.size() == 0) begin
        if (mismatches < 10) $display("unexpected result %p", out_item);
        mismatches <= mismatches + 1;
      end else begin
        status_seen[out_item.status] <= status_seen[out_item.status] + 1;
        if (out_item !== boosted_due[0]) begin
          if (mismatches < 10)
            $display("mismatch: expected %p, got %p", boosted_due[0], out_item);
          mismatches <= mismatches + 1;
        end
        void'(boosted_due.pop_front());
      end
    end
    if (cycles > CYCLE_CAP) begin
      $display("timeout after %0d cycles", cycles);
      $display("[lorentz_boost_three_vector] ERROR");
      $finish;
    end
  end

  task automatic drain_pipe();
    while (pending_items.size() != 0 || boosted_due.size() != 0 || start)
      @(posedge clk);
    repeat (LATENCY + 8) @(posedge clk);
  endtask

  task automatic write_threshold(input logic [THR_W-1:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    thr_model = val;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic queue_random(input int n);
    logic signed [31:0] vx, vy, vz;
    for (int k = 0; k < n; k++) begin
      vx = rand_speed(); vy = rand_speed(); vz = rand_speed();
      if ($urandom_range(0, 4) == 0) begin
        vy = $signed($urandom_range(0, 64)) - 32;
        vz = 0;
      end
      pending_items.push_back(make_item(1'($urandom_range(0, 1)), rand_comp(), rand_comp(),
                                        rand_comp(), vx, vy, vz));
    end
  endtask

  initial begin
    logic signed [31:0] mx, mn, one;
    mx = 32'sh7FFF_FFFF; mn = 32'sh8000_0000; one = 32'sh4000_0000;
    thr_model = 61'd256;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    pending_items.push_back(make_item(OP_GAMMA, 1, 2, 3, 0, 0, 0));
    pending_items.push_back(make_item(OP_GAMMA, mx, mn, 0, 16, 0, 0));
    pending_items.push_back(make_item(OP_INV, mx, mn, 0, 17, 0, 0));
    pending_items.push_back(make_item(OP_GAMMA, 32'sh10000, 0, 0, one, 0, 0));
    pending_items.push_back(make_item(OP_INV, 5, 6, 7, -one, 0, 0));
    pending_items.push_back(make_item(OP_GAMMA, 0, 0, 0, mx, mx, mx));
    pending_items.push_back(make_item(OP_INV, mn, mn, mn, mn, mn, mn));
    pending_items.push_back(make_item(OP_GAMMA, 32'sh10000, 32'sh20000, -32'sh30000,
                                      32'sh3000_0000, 0, 0));
    pending_items.push_back(make_item(OP_INV, 32'sh10000, 32'sh20000, -32'sh30000,
                                      -32'sh2000_0000, 32'sh1000_0000, 32'sh0800_0000));
    pending_items.push_back(make_item(OP_GAMMA, mx, mx, mx, 32'sh3FFF_0000, 0, 0));
    pending_items.push_back(make_item(OP_GAMMA, mn, mn, mn, 32'sh3FFF_0000, 0, 0));
    pending_items.push_back(make_item(OP_INV, mx, mn, mx, -32'sh3FFF_F000, 0, 0));
    pending_items.push_back(make_item(OP_GAMMA, mn, mx, mn, 32'sh3FFF_FFFF, 0, 0));
    pending_items.push_back(make_item(OP_INV, -1, 1, -1, 32'sh2000_0000, -32'sh2000_0000,
                                      32'sh2000_0000));
    drain_pipe();

    write_threshold('0);
    pending_items.push_back(make_item(OP_GAMMA, 1, 1, 1, 1, 0, 0));
    pending_items.push_back(make_item(OP_GAMMA, 1, 1, 1, 0, 0, 0));
    queue_random(300);
    drain_pipe();

    write_threshold(61'h1FFF_FFFF_FFFF_FFFF);
    pending_items.push_back(make_item(OP_INV, mx, mx, mx, one, one, one));
    queue_random(60);
    drain_pipe();

    write_threshold(61'd1 << 58);
    queue_random(200);
    drain_pipe();

    write_threshold(61'd1 << 60);
    pending_items.push_back(make_item(OP_GAMMA, 3, 3, 3, one, 0, 0));
    queue_random(40);
    drain_pipe();

    write_threshold(61'd256);
    idle_on = 1'b0;
    queue_random(200);
    drain_pipe();
    idle_on = 1'b1;
    queue_random(200);
    repeat (100) @(posedge clk);
    hold_sender = 1'b1;
    repeat (2) @(posedge clk);
    while (boosted_due.size() != 0) @(posedge clk);
    hold_sender = 1'b0;
    queue_random(50);
    drain_pipe();

    $display("%0d results checked across six threshold settings", results_seen);
    $display("status counts ok/pass/invalid/sat: %0d/%0d/%0d/%0d", status_seen[0],
             status_seen[1], status_seen[2], status_seen[3]);
    if (mismatches == 0 && boosted_due.size() == 0) begin
      $display("[lorentz_boost_three_vector] OK");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("[lorentz_boost_three_vector] ERROR");
    end
    $finish;
  end
endmodule

// ===== files.f =====
rtl/core/lbtv_pkg.sv
rtl/core/lbtv_isqrt.sv
rtl/core/lbtv_div.sv
rtl/core/lorentz_boost_three_vector.sv
sim/lorentz_boost_three_vector_tb.sv
